### sv/fsp_pkg.sv
// fsp_pkg: widths, register indexes, run mode codes and the divider
// request/response structs of the fixed-step frame pacer.
// No dependencies; used by every file under sv/.
package fsp_pkg;

  localparam int TIME_W  = 32;
  localparam int STEP_W  = 16;
  localparam int SKIP_W  = 4;
  localparam int BANK_W  = 24;
  localparam int BLEND_W = 24;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int BLEND_FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SKIP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMITER_ON = 2'd2;

  // configuration reset values
  localparam logic [STEP_W-1:0] STEP_MS_RST  = 16'd33;
  localparam logic [SKIP_W-1:0] MAX_SKIP_RST = 4'd2;
  localparam logic              LIMITER_RST  = 1'b0;

  // run mode codes
  localparam logic [MODE_W-1:0] MODE_BOTH   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SIM    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RENDER = 2'd2;

  typedef struct packed {
    logic              start;
    logic              flush;
    logic [STEP_W-1:0] divisor;
    logic [BANK_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [BLEND_W-1:0] blend;
    logic [BANK_W-1:0]  bank;
  } div_rsp_t;

endpackage

### sv/fixed_step_frame_pacer.sv
// fixed_step_frame_pacer: top level of the fixed-step frame pacer.
// Depends on fsp_pkg and fsp_div.
//
// Usage: one input item per frame carries now_ms; one result item comes
// back per frame with run mode, adjusted frame time, old skip count, blend
// fraction and tick count. Configuration (step_ms, max_skip, limiter_on)
// is written on the cfg channel by index; the user must write it only while
// the block is idle, which it does not enforce; cfg_ready is always high.
// Steps: accept in S_IDLE, then S_CAP; in limiter mode on to S_OUT, else
// S_ADD, S_DEC and S_DIV, which waits for the divider, then S_OUT. The
// blend quotient and the bank flush share one bit-serial divider, one
// quotient bit per cycle.
// Throughput: one item at a time; in_ready is high only between items,
// so a new item is taken only after the last one has left S_OUT.
// A new item is accepted while the previous result still waits in the
// output register; its result is held back until that register is free.
// A stalled receiver therefore holds at most one finished item plus one at
// work. Reset (rst_n low, synchronous) restores the register defaults and
// clears the time bank, skip count, tick count and last-frame time.
module fixed_step_frame_pacer #(
  parameter int BLEND_FRAC_BITS = fsp_pkg::BLEND_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [fsp_pkg::TIME_W-1:0]         in_now_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [fsp_pkg::MODE_W-1:0]         out_run_mode,
  output logic [fsp_pkg::TIME_W-1:0]         out_frame_ms,
  output logic [fsp_pkg::SKIP_W-1:0]         out_skips_seen,
  output logic [fsp_pkg::BLEND_W-1:0]        out_blend_q16,
  output logic [fsp_pkg::TIME_W-1:0]         out_sim_tick,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int TIME_W  = fsp_pkg::TIME_W;
  localparam int STEP_W  = fsp_pkg::STEP_W;
  localparam int SKIP_W  = fsp_pkg::SKIP_W;
  localparam int BANK_W  = fsp_pkg::BANK_W;
  localparam int BLEND_W = fsp_pkg::BLEND_W;
  localparam int MODE_W  = fsp_pkg::MODE_W;
  localparam int MUL_W   = STEP_W + SKIP_W + 1;
  localparam logic [BLEND_W-1:0] LIM_BLEND = (BLEND_FRAC_BITS >= BLEND_W) ?
                                             {BLEND_W{1'b1}} :
                                             BLEND_W'(1) << BLEND_FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_CAP, S_ADD, S_DEC, S_DIV, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [STEP_W-1:0] step_ms_r;
  logic [SKIP_W-1:0] max_skip_r;
  logic              limiter_r;

  // frame state
  logic [TIME_W-1:0] prev_r;
  logic [BANK_W-1:0] bank_r;
  logic [SKIP_W-1:0] skip_r;
  logic [TIME_W-1:0] tick_r;

  // per item working registers
  logic [TIME_W-1:0]  elapsed_r;
  logic [SKIP_W-1:0]  seen_r;
  logic [MUL_W-1:0]   cap_r;
  logic [MODE_W-1:0]  mode_r;
  logic [TIME_W-1:0]  frame_r;
  logic [BLEND_W-1:0] blend_r;

  // output register
  logic               out_valid_r;
  logic [MODE_W-1:0]  out_mode_r;
  logic [TIME_W-1:0]  out_frame_r;
  logic [SKIP_W-1:0]  out_seen_r;
  logic [BLEND_W-1:0] out_blend_r;
  logic [TIME_W-1:0]  out_tick_r;

  logic [STEP_W-1:0]  step_eff;
  logic [SKIP_W:0]    mul_b;
  logic [MUL_W-1:0]   prod;
  logic [MUL_W-1:0]   add_v;
  logic [BANK_W:0]    sum;
  logic [BANK_W-1:0]  bank_sat;
  logic               ge1;
  logic               ge2;
  logic [BANK_W-1:0]  bank_less;
  logic               in_acc;
  logic               out_free;

  fsp_pkg::div_req_t div_req;
  fsp_pkg::div_rsp_t div_rsp;

  fsp_div #(
    .BLEND_FRAC_BITS(BLEND_FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    step_eff  = (step_ms_r == '0) ? STEP_W'(1) : step_ms_r;
    // one small multiplier: clamp limit first, then step times old skips
    mul_b     = (state_r == S_CAP) ? ({1'b0, max_skip_r} + (SKIP_W + 1)'(1))
                                   : {1'b0, skip_r};
    prod      = MUL_W'(step_eff) * MUL_W'(mul_b);
    add_v     = (elapsed_r < TIME_W'(cap_r)) ? elapsed_r[MUL_W-1:0] : cap_r;
    sum       = (BANK_W + 1)'(bank_r) + (BANK_W + 1)'(add_v);
    bank_sat  = sum[BANK_W] ? {BANK_W{1'b1}} : sum[BANK_W-1:0];
    ge1       = bank_r >= BANK_W'(step_eff);
    ge2       = {1'b0, bank_r} >= ((BANK_W + 1)'(step_eff) << 1);
    bank_less = bank_r - BANK_W'(step_eff);
    in_acc    = in_valid && in_ready;
    out_free  = !out_valid_r || out_ready;

    div_req.start    = (state_r == S_DEC);
    div_req.flush    = ge1 && !(skip_r < max_skip_r);
    div_req.divisor  = step_eff;
    div_req.dividend = ge1 ? bank_less : bank_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_ms_r   <= fsp_pkg::STEP_MS_RST;
      max_skip_r  <= fsp_pkg::MAX_SKIP_RST;
      limiter_r   <= fsp_pkg::LIMITER_RST;
      prev_r      <= '0;
      bank_r      <= '0;
      skip_r      <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          fsp_pkg::CFG_STEP_MS:    step_ms_r  <= cfg_wdata[STEP_W-1:0];
          fsp_pkg::CFG_MAX_SKIP:   max_skip_r <= cfg_wdata[SKIP_W-1:0];
          fsp_pkg::CFG_LIMITER_ON: limiter_r  <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            // a last time of zero means no frame yet
            elapsed_r <= (prev_r == '0) ? '0 : in_now_ms - prev_r;
            prev_r    <= in_now_ms;
            seen_r    <= skip_r;
            state_r   <= S_CAP;
          end
        end
        S_CAP: begin
          if (limiter_r) begin
            mode_r  <= fsp_pkg::MODE_BOTH;
            frame_r <= elapsed_r;
            blend_r <= LIM_BLEND;
            tick_r  <= tick_r + TIME_W'(1);
            state_r <= S_OUT;
          end else begin
            cap_r   <= prod;
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          bank_r  <= bank_sat;
          frame_r <= elapsed_r + TIME_W'(prod);
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (ge1) begin
            bank_r <= bank_less;
            tick_r <= tick_r + TIME_W'(1);
            if (skip_r < max_skip_r && ge2) begin
              mode_r <= fsp_pkg::MODE_SIM;
              skip_r <= skip_r + SKIP_W'(1);
            end else begin
              mode_r <= fsp_pkg::MODE_BOTH;
              skip_r <= '0;
            end
          end else begin
            mode_r <= fsp_pkg::MODE_RENDER;
            skip_r <= '0;
          end
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            bank_r  <= div_rsp.bank;
            blend_r <= div_rsp.blend;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_mode_r  <= mode_r;
            out_frame_r <= frame_r;
            out_seen_r  <= seen_r;
            out_blend_r <= blend_r;
            out_tick_r  <= tick_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_run_mode   = out_mode_r;
  assign out_frame_ms   = out_frame_r;
  assign out_skips_seen = out_seen_r;
  assign out_blend_q16  = out_blend_r;
  assign out_sim_tick   = out_tick_r;

endmodule

### sv/fsp_div.sv
// fsp_div: bit-serial restoring divider for the blend fraction and the
// bank flush (bank modulo step falls out after the integer bits).
// Depends on fsp_pkg.
module fsp_div #(
  parameter int BLEND_FRAC_BITS = fsp_pkg::BLEND_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fsp_pkg::div_req_t req,
  output fsp_pkg::div_rsp_t rsp
);

  localparam int BANK_W  = fsp_pkg::BANK_W;
  localparam int STEP_W  = fsp_pkg::STEP_W;
  localparam int BLEND_W = fsp_pkg::BLEND_W;
  localparam int DIV_LEN = BANK_W + BLEND_FRAC_BITS;
  localparam int CNT_W   = $clog2(DIV_LEN);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_LEN - 1);
  localparam logic [CNT_W-1:0] CNT_MOD  = CNT_W'(BANK_W - 1);

  logic               busy_r;
  logic               done_r;
  logic               flush_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [STEP_W-1:0]  div_r;
  logic [STEP_W-1:0]  rem_r;
  logic [BANK_W-1:0]  dvd_r;
  logic [BLEND_W-1:0] q_r;
  logic               sat_r;
  logic [BANK_W-1:0]  mod_r;

  logic [STEP_W:0]    shifted;
  logic [STEP_W:0]    diff;
  logic               ge;
  logic [STEP_W-1:0]  rem_nxt;
  logic [BLEND_W-1:0] q_nxt;
  logic               sat_nxt;

  always_comb begin
    shifted = {rem_r, dvd_r[BANK_W-1]};
    ge      = shifted >= {1'b0, div_r};
    diff    = shifted - {1'b0, div_r};
    rem_nxt = ge ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
    q_nxt   = {q_r[BLEND_W-2:0], ge};
    // any quotient bit above the result width means saturation
    sat_nxt = sat_r | q_r[BLEND_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        rem_r   <= '0;
        dvd_r   <= req.dividend;
        q_r     <= '0;
        sat_r   <= 1'b0;
        div_r   <= req.divisor;
        flush_r <= req.flush;
        mod_r   <= req.dividend;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[BANK_W-2:0], 1'b0};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_MOD && flush_r) begin
          // last bank bit consumed: remainder is the flushed bank, integer part drops
          mod_r <= BANK_W'(rem_nxt);
          q_r   <= '0;
          sat_r <= 1'b0;
        end else begin
          q_r   <= q_nxt;
          sat_r <= sat_nxt;
        end
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.blend = sat_r ? {BLEND_W{1'b1}} : q_r;
  assign rsp.bank  = mod_r;

endmodule

### sv/fsp_chk.sv
// fsp_chk: port-level checker for the fixed-step frame pacer, bound to
// the top level below. Depends on fsp_pkg.
module fsp_chk #(
  parameter int BLEND_FRAC_BITS = fsp_pkg::BLEND_FRAC_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fsp_pkg::MODE_W-1:0]  out_run_mode,
  input logic [fsp_pkg::TIME_W-1:0]  out_frame_ms,
  input logic [fsp_pkg::BLEND_W-1:0] out_blend_q16,
  input logic [fsp_pkg::TIME_W-1:0]  out_sim_tick
);

  localparam int BLEND_W = fsp_pkg::BLEND_W;
  localparam logic [BLEND_W:0] ONE_Q = (BLEND_W + 1)'(1) << BLEND_FRAC_BITS;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_ms)
      && $stable(out_sim_tick) && $stable(out_blend_q16))
    else $error("result item changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous one at work");

  // a catch-up frame still has at least one full step banked
  a_sim_blend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_mode == fsp_pkg::MODE_SIM |->
      {1'b0, out_blend_q16} >= ONE_Q || out_blend_q16 == {BLEND_W{1'b1}})
    else $error("simulate-only frame with blend below one");

  // a render-only frame has less than one step banked
  a_render_blend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_mode == fsp_pkg::MODE_RENDER |->
      {1'b0, out_blend_q16} < ONE_Q)
    else $error("render-only frame with blend of one or more");

endmodule

bind fixed_step_frame_pacer fsp_chk #(
  .BLEND_FRAC_BITS(BLEND_FRAC_BITS)
) u_fsp_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_run_mode (out_run_mode),
  .out_frame_ms (out_frame_ms),
  .out_blend_q16(out_blend_q16),
  .out_sim_tick (out_sim_tick)
);

### tb/sv/tb_fixed_step_frame_pacer.sv
// tb_fixed_step_frame_pacer: self-checking testbench for the fixed-step frame pacer.
// Holds a frame-pacing scoreboard class and the tasks that drive frames and register writes.
// Depends on fsp_pkg and fixed_step_frame_pacer.
`timescale 1ns / 100ps

module tb_fixed_step_frame_pacer;

  localparam int TIME_W     = fsp_pkg::TIME_W;
  localparam int STEP_W     = fsp_pkg::STEP_W;
  localparam int SKIP_W     = fsp_pkg::SKIP_W;
  localparam int BANK_W     = fsp_pkg::BANK_W;
  localparam int BLEND_W    = fsp_pkg::BLEND_W;
  localparam int MODE_W     = fsp_pkg::MODE_W;
  localparam int CFG_IDX_W  = fsp_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = fsp_pkg::CFG_DATA_W;

  localparam int FRAC_BITS    = fsp_pkg::BLEND_FRAC_BITS_DEF;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 54;
  localparam int SETTLE_CYCLES = 60;
  localparam int LIMIT_CYCLES = 600000;
  localparam int MAX_PRINTED  = 40;

  typedef struct packed {
    logic [MODE_W-1:0]  run_mode;
    logic [TIME_W-1:0]  frame_ms;
    logic [SKIP_W-1:0]  skips_seen;
    logic [BLEND_W-1:0] blend_q16;
    logic [TIME_W-1:0]  sim_tick;
  } pacer_result_t;

  class frame_pacer_scoreboard;
    logic [STEP_W-1:0] cfg_step     = fsp_pkg::STEP_MS_RST;
    logic [SKIP_W-1:0] cfg_max_skip = fsp_pkg::MAX_SKIP_RST;
    logic              cfg_limiter  = fsp_pkg::LIMITER_RST;
    logic [TIME_W-1:0] last_ms      = '0;
    logic [BANK_W-1:0] bank_ms      = '0;
    logic [SKIP_W-1:0] skip_run     = '0;
    logic [TIME_W-1:0] tick_total   = '0;
    pacer_result_t     expected_frames[$];
    int errors = 0;
    int checked = 0;
    int sim_only = 0;
    int render_only = 0;
    int limited = 0;
    int reg_writes = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx,
                          logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        fsp_pkg::CFG_STEP_MS:    cfg_step = data;
        fsp_pkg::CFG_MAX_SKIP:   cfg_max_skip = data[SKIP_W-1:0];
        fsp_pkg::CFG_LIMITER_ON: cfg_limiter = data[0];
        default: ;
      endcase
    endfunction

    // works out the result of one accepted frame and advances the pacing state
    function void note_frame(logic [TIME_W-1:0] now);
      logic [31:0] step, elapsed, cap, add;
      logic [63:0] sum, blend;
      pacer_result_t r;
      step = (cfg_step == '0) ? 32'd1 : {16'd0, cfg_step};
      if (last_ms == '0) last_ms = now;
      elapsed = now - last_ms;
      last_ms = now;
      r.skips_seen = skip_run;
      if (cfg_limiter) begin
        r.run_mode = fsp_pkg::MODE_BOTH;
        r.frame_ms = elapsed;
        blend = 64'd1 << FRAC_BITS;
        limited++;
      end else begin
        cap = step * ({28'd0, cfg_max_skip} + 32'd1);
        add = (elapsed < cap) ? elapsed : cap;
        sum = {40'd0, bank_ms} + {32'd0, add};
        bank_ms = (sum > 64'hFF_FFFF) ? 24'hFF_FFFF : sum[23:0];
        r.frame_ms = elapsed + step * {28'd0, skip_run};
        if ({8'd0, bank_ms} >= step) begin
          bank_ms = bank_ms - step[23:0];
          if (skip_run < cfg_max_skip) begin
            if ({8'd0, bank_ms} >= step) begin
              r.run_mode = fsp_pkg::MODE_SIM;
              skip_run = skip_run + 4'd1;
            end else begin
              r.run_mode = fsp_pkg::MODE_BOTH;
              skip_run = '0;
            end
          end else begin
            // skip budget spent: drop whole steps still banked
            bank_ms = bank_ms % step[23:0];
            skip_run = '0;
            r.run_mode = fsp_pkg::MODE_BOTH;
          end
        end else begin
          r.run_mode = fsp_pkg::MODE_RENDER;
          skip_run = '0;
        end
        blend = ({40'd0, bank_ms} << FRAC_BITS) / {32'd0, step};
      end
      if (r.run_mode != fsp_pkg::MODE_RENDER) tick_total = tick_total + 32'd1;
      if (r.run_mode == fsp_pkg::MODE_SIM) sim_only++;
      if (r.run_mode == fsp_pkg::MODE_RENDER) render_only++;
      r.blend_q16 = (blend > 64'hFF_FFFF) ? 24'hFF_FFFF : blend[23:0];
      r.sim_tick = tick_total;
      expected_frames.insert(expected_frames.size(), r);
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("ERROR result %0d: %s", checked, msg);
    endtask

    task check_result(pacer_result_t got);
      pacer_result_t want;
      if (expected_frames.size() == 0) begin
        report("result with no frame pending");
        return;
      end
      want = expected_frames.pop_front();
      checked++;
      if (got.run_mode != want.run_mode)
        report($sformatf("run_mode got %0d want %0d", got.run_mode, want.run_mode));
      if (got.frame_ms != want.frame_ms)
        report($sformatf("frame_ms got %0h want %0h", got.frame_ms, want.frame_ms));
      if (got.skips_seen != want.skips_seen)
        report($sformatf("skips_seen got %0d want %0d", got.skips_seen, want.skips_seen));
      if (got.blend_q16 != want.blend_q16)
        report($sformatf("blend_q16 got %0h want %0h", got.blend_q16, want.blend_q16));
      if (got.sim_tick != want.sim_tick)
        report($sformatf("sim_tick got %0d want %0d", got.sim_tick, want.sim_tick));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [MODE_W-1:0]     out_run_mode;
  logic [TIME_W-1:0]     out_frame_ms;
  logic [SKIP_W-1:0]     out_skips_seen;
  logic [BLEND_W-1:0]    out_blend_q16;
  logic [TIME_W-1:0]     out_sim_tick;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  frame_pacer_scoreboard sb = new();

  int          cycle_count = 0;
  int          hold_cycles = 0;
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  logic [31:0] wall_ms = '0;
  logic [15:0] cur_step = fsp_pkg::STEP_MS_RST;
  logic [3:0]  cur_max_skip = fsp_pkg::MAX_SKIP_RST;

  fixed_step_frame_pacer #(.BLEND_FRAC_BITS(FRAC_BITS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_run_mode   (out_run_mode),
    .out_frame_ms   (out_frame_ms),
    .out_skips_seen (out_skips_seen),
    .out_blend_q16  (out_blend_q16),
    .out_sim_tick   (out_sim_tick),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("run stopped at the cycle limit with %0d results pending", sb.pending());
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin : watch_results
    pacer_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.run_mode   = out_run_mode;
      got.frame_ms   = out_frame_ms;
      got.skips_seen = out_skips_seen;
      got.blend_q16  = out_blend_q16;
      got.sim_tick   = out_sim_tick;
      sb.check_result(got);
    end
  end

  // result side: random stalls per item, plus a long hold when asked for
  initial begin : rx_side
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 19) : 0;
      stall += hold_cycles;
      hold_cycles = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_frame(input logic [31:0] now);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_now_ms <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_frame(now);
    wall_ms = now;
  endtask

  // leaves cfg_valid high so that back-to-back writes need no lowering
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic set_config(input logic [15:0] step, input logic [3:0] max_skip,
                            input logic limiter);
    write_reg(fsp_pkg::CFG_STEP_MS, step);
    write_reg(fsp_pkg::CFG_MAX_SKIP, {12'd0, max_skip});
    write_reg(fsp_pkg::CFG_LIMITER_ON, {15'd0, limiter});
    cfg_valid <= 1'b0;
    cur_step = step;
    cur_max_skip = max_skip;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly time moving forward by up to (max skip + 3) steps; some jumps, zeros and wraps
  function automatic logic [31:0] pick_now();
    logic [31:0] step_eff, span;
    int r;
    step_eff = (cur_step == 16'd0) ? 32'd1 : {16'd0, cur_step};
    span = step_eff * ({28'd0, cur_max_skip} + 32'd3);
    r = $urandom_range(0, 99);
    if (r < 7) return $urandom();
    if (r < 9) return 32'd0;
    if (r < 25) return wall_ms + $urandom_range(0, step_eff - 1);
    return wall_ms + $urandom_range(0, span);
  endfunction

  initial begin : stimulus
    logic [15:0] step;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames at the reset settings: time zero, first frame, wrap
    send_frame(32'd0);
    send_frame(32'd0);
    send_frame(32'd1000);
    send_frame(32'd1033);
    send_frame(32'd1040);
    send_frame(32'd1140);
    send_frame(32'd1141);
    send_frame(32'd1200);
    send_frame(32'hFFFF_FFF0);
    send_frame(32'h0000_0010);
    send_frame(32'hFFFF_FFFF);
    drain();

    // zero step behaves as one
    set_config(16'd0, 4'd15, 1'b0);
    send_frame(wall_ms + 32'd20);
    send_frame(wall_ms + 32'd20);
    drain();

    // large bank under the longest step, then a tiny step saturates the blend
    set_config(16'hFFFF, 4'd15, 1'b0);
    send_frame(wall_ms + 32'd1000000);
    send_frame(wall_ms + 32'd1000000);
    send_frame(wall_ms + 32'd1000000);
    drain();
    set_config(16'd1, 4'd15, 1'b0);
    send_frame(wall_ms + 32'd5);
    drain();

    // skip budget lowered under the running count takes the flush path
    set_config(16'd1, 4'd0, 1'b0);
    send_frame(wall_ms + 32'd1);
    drain();

    set_config(16'd33, 4'd2, 1'b1);
    send_frame(wall_ms + 32'd7);
    send_frame(wall_ms + 32'd123456);
    send_frame(32'd0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_config(16'd1, 4'd0, 1'b0);
        1: set_config(16'hFFFF, 4'd15, 1'b0);
        2: set_config(16'd0, 4'd15, 1'b0);
        3: set_config(16'd33, 4'd2, 1'b0);
        4: set_config(16'($urandom_range(1, 100)), 4'($urandom_range(0, 15)), 1'b1);
        default: begin
          case ($urandom_range(0, 9))
            0: step = 16'd0;
            1: step = 16'hFFFF;
            2: step = 16'($urandom_range(1, 65535));
            default: step = 16'($urandom_range(1, 100));
          endcase
          set_config(step, 4'($urandom_range(0, 15)), $urandom_range(0, 5) == 0);
        end
      endcase
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 4) == 0) wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == 20) begin
          // receiver holds off while frames keep coming, so the block backs up
          hold_cycles = 400;
          tx_idle = 1'b0;
        end
        if (ph == 6 && k == 27) drain();
        send_frame(pick_now());
      end
      drain();
    end

    $display("%0d frames checked under %0d register writes", sb.checked, sb.reg_writes);
    $display("%0d catch-up frames, %0d render-only frames, %0d limiter frames",
             sb.sim_only, sb.render_only, sb.limited);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
sv/fsp_pkg.sv
sv/fsp_div.sv
sv/fixed_step_frame_pacer.sv
sv/fsp_chk.sv
tb/sv/tb_fixed_step_frame_pacer.sv
